// File: hw/rtl/plst_pkg.sv
// shared types, constants and helpers for the spline trainer
package plst_pkg;

  localparam int MAX_KNOTS_DEF = 64;
  localparam int DVW = 49;
  localparam int DSW = 33;
  localparam int MAW = 33;
  localparam int MBW = 25;
  localparam int PRW = MAW + MBW;

  localparam logic [6:0]  POINTS_RESET = 7'd64;
  localparam logic [23:0] RATE_RESET   = 24'd655;
  localparam logic [15:0] RECIP_HI = 16'h51eb;
  localparam logic [15:0] RECIP_LO = 16'h851f;
  localparam int RECIP_SH = 37;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam logic [16:0] ONE_FRAC = 17'h10000;

  typedef enum logic [0:0] {
    REG_POINTS = 1'b0,
    REG_RATE   = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_DOMAIN = 3'd0,
    MODE_LOAD   = 3'd1,
    MODE_EVAL   = 3'd2,
    MODE_SLOPE  = 3'd3,
    MODE_UPD_X  = 3'd4,
    MODE_UPD_M  = 3'd5
  } mode_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/plst_ram.sv
// generic single write, single registered read memory
module plst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/plst_div.sv
// iterative signed restoring divider, one quotient bit per cycle, truncating
module plst_div import plst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [DVW-1:0] dividend,
  input  logic signed [DSW-1:0] divisor,
  output logic                  done,
  output logic signed [DVW:0]   quotient
);
  localparam int CNW = $clog2(DVW);

  logic           running;
  logic [CNW-1:0] cnt;
  logic [DSW-1:0] rem;
  logic [DVW-1:0] quo;
  logic [DSW-1:0] dsr;
  logic           neg;
  logic [DSW+1:0] diff;

  assign diff = {1'b0, rem, quo[DVW-1]} - {2'b00, dsr};
  assign quotient = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt <= '0;
        rem <= '0;
        quo <= dividend[DVW-1] ? DVW'(-dividend) : DVW'(dividend);
        dsr <= divisor[DSW-1] ? DSW'(-divisor) : DSW'(divisor);
        neg <= dividend[DVW-1] ^ divisor[DSW-1];
      end else if (running) begin
        if (!diff[DSW+1]) begin
          rem <= diff[DSW-1:0];
          quo <= {quo[DVW-2:0], 1'b1};
        end else begin
          rem <= {rem[DSW-2:0], quo[DVW-1]};
          quo <= {quo[DVW-2:0], 1'b0};
        end
        if (cnt == CNW'(DVW - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end
endmodule

// File: hw/rtl/plst_mul.sv
// shared signed multiplier with registered product
module plst_mul import plst_pkg::*; (
  input  logic                  clk,
  input  logic signed [MAW-1:0] a,
  input  logic signed [MBW-1:0] b,
  output logic signed [PRW-1:0] prod
);
  always_ff @(posedge clk) begin
    prod <= PRW'(a) * PRW'(b);
  end
endmodule

// File: hw/rtl/piecewise_linear_spline_trainer_unit.sv
// top level: sequencer around a shared divider and multiplier, knot table memory
//
// channel   direction  signals                                       transaction
// command   in         start, busy, mode, x, domain_top, delta,       start & !busy
//                      knot_index, knot_value
// result    out        done, value, status                           done (one cycle)
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data     cfg_valid & cfg_ready
//
// divisions run on the shared restoring divider; the margin uses a reciprocal multiply
// load, zero-spacing slope and spare modes answer the cycle after accept, busy stays low
// each widening of the domain reruns the margin and the spacing division
// rst is synchronous, clears domain, spacing and memory of cell, and resets the registers to defaults
// busy is high from accept until the result strobe; results cannot be stalled
module piecewise_linear_spline_trainer_unit import plst_pkg::*; #(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic signed [31:0] x,
  input  logic signed [31:0] domain_top,
  input  logic signed [31:0] delta,
  input  logic [5:0]         knot_index,
  input  logic signed [31:0] knot_value,
  output logic               done,
  output logic signed [31:0] value,
  output logic               status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  localparam int CW = $clog2(MAX_KNOTS);
  localparam int PW = ($clog2(MAX_KNOTS + 1) > 7) ? $clog2(MAX_KNOTS + 1) : 7;

  typedef enum logic [21:0] {
    S_IDLE   = 22'h000001,
    S_WLO    = 22'h000002,
    S_WHI    = 22'h000004,
    S_CHK    = 22'h000008,
    S_MDIV   = 22'h000010,
    S_MWAIT  = 22'h000020,
    S_SDIV   = 22'h000040,
    S_SWAIT  = 22'h000080,
    S_LDIV   = 22'h000100,
    S_LWAIT  = 22'h000200,
    S_RD0    = 22'h000400,
    S_RD1    = 22'h000800,
    S_RD2    = 22'h001000,
    S_IMUL   = 22'h002000,
    S_IRES   = 22'h004000,
    S_SLDIV  = 22'h008000,
    S_SLWAIT = 22'h010000,
    S_U0     = 22'h020000,
    S_U1     = 22'h040000,
    S_U2     = 22'h080000,
    S_U3     = 22'h100000,
    S_MSUM   = 22'h200000
  } state_t;

  state_t state;
  logic [2:0]         op;
  logic signed [31:0] xr, deltar;
  logic signed [31:0] low, high, spacing;
  logic [CW-1:0]      last_cell, seg;
  logic [15:0]        last_fraction, frac;
  logic [6:0]         points_in_use;
  logic [23:0]        learning_rate;
  logic               after_hi;
  logic signed [31:0] y0, y1, d;
  logic [47:0]        mlo;

  logic [PW-1:0] p_eff, last;
  always_comb begin
    p_eff = PW'(points_in_use);
    if (p_eff < PW'(2)) p_eff = PW'(2);
    if (p_eff > PW'(MAX_KNOTS)) p_eff = PW'(MAX_KNOTS);
    last = p_eff - PW'(2);
  end

  // domain range magnitude for the margin
  logic signed [32:0] rng;
  logic [31:0]        rng_mag;
  assign rng = 33'(high) - 33'(low);
  assign rng_mag = rng[32] ? 32'(-rng) : 32'(rng);

  // shared divider
  logic                  div_start, div_done;
  logic signed [DVW-1:0] div_a;
  logic signed [DSW-1:0] div_b;
  logic signed [DVW:0]   div_q;
  logic signed [32:0]    dy;
  assign dy = 33'(y1) - 33'(y0);

  always_comb begin
    div_start = 1'b0;
    div_a = DVW'(rng);
    div_b = $signed(DSW'(p_eff - PW'(1)));
    case (state)
      S_SDIV: begin
        div_start = 1'b1;
      end
      S_LDIV: begin
        div_start = 1'b1;
        div_a = $signed({33'(xr) - 33'(low), 16'h0000});
        div_b = DSW'(spacing);
      end
      S_SLDIV: begin
        div_start = 1'b1;
        div_a = $signed({dy, 16'h0000});
        div_b = DSW'(spacing);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  plst_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  // shared multiplier
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PRW-1:0] prod;
  logic signed [31:0]    d_new, prod_sh_sum;
  assign d_new = sat32(64'(prod >>> 16));

  always_comb begin
    mul_a = MAW'(deltar);
    mul_b = $signed(MBW'(learning_rate));
    case (state)
      S_MDIV: begin
        mul_a = $signed({1'b0, rng_mag});
        mul_b = $signed(MBW'(RECIP_LO));
      end
      S_MWAIT: begin
        mul_a = $signed({1'b0, rng_mag});
        mul_b = $signed(MBW'(RECIP_HI));
      end
      S_IMUL: begin
        mul_a = dy;
        mul_b = $signed(MBW'(frac));
      end
      S_U1: begin
        mul_a = MAW'(d_new);
        mul_b = $signed(MBW'(frac));
      end
      S_U2: begin
        mul_a = MAW'(d);
        mul_b = $signed(MBW'(ONE_FRAC - 17'(frac)));
      end
      default: begin
        mul_a = MAW'(deltar);
      end
    endcase
  end

  plst_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  // knot table
  logic          ram_we;
  logic [CW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  assign prod_sh_sum = sat32(64'(state == S_U2 ? y1 : y0) + 64'(prod >>> 16));

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = seg;
    ram_wdata = prod_sh_sum;
    ram_raddr = (state == S_RD1) ? seg + CW'(1) : seg;
    case (state)
      S_IDLE: begin
        ram_we = start && (mode == MODE_LOAD) && (32'(knot_index) < 32'(MAX_KNOTS));
        ram_waddr = CW'(knot_index);
        ram_wdata = knot_value;
      end
      S_U2: begin
        ram_we = 1'b1;
        ram_waddr = seg + CW'(1);
      end
      S_U3: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  plst_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // datapath helpers
  logic signed [31:0] margin_low, margin_high, spc_new;
  logic [63:0]        mg_full;
  logic signed [31:0] mq, mg;
  logic [CW-1:0]      loc_cell;
  logic [15:0]        loc_frac;
  logic [32:0]        q_hi;
  assign mg_full     = 64'({prod[46:0], 16'h0000}) + 64'(mlo);
  assign mq          = $signed(32'(mg_full >> RECIP_SH));
  assign mg          = rng[32] ? -mq : mq;
  assign margin_low  = sat32(64'(low) - 64'(mg));
  assign margin_high = sat32(64'(high) + 64'(mg));
  assign spc_new     = sat32(64'(div_q));
  assign q_hi        = div_q[DVW-1:16];

  always_comb begin
    if (div_q[DVW]) begin
      loc_cell = '0;
      loc_frac = '0;
    end else if (q_hi > 33'(last)) begin
      loc_cell = CW'(last);
      loc_frac = 16'hffff;
    end else begin
      loc_cell = CW'(q_hi);
      loc_frac = div_q[15:0];
    end
  end

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      value <= '0;
      status <= 1'b0;
      low <= '0;
      high <= '0;
      spacing <= '0;
      last_cell <= '0;
      last_fraction <= '0;
      points_in_use <= POINTS_RESET;
      learning_rate <= RATE_RESET;
      after_hi <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_POINTS: points_in_use <= cfg_data[6:0];
          REG_RATE:   learning_rate <= cfg_data;
          default:    learning_rate <= learning_rate;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= mode;
            xr <= x;
            deltar <= delta;
            value <= '0;
            status <= 1'b0;
            case (mode)
              MODE_DOMAIN: begin
                low <= x;
                high <= domain_top;
                state <= S_MDIV;
              end
              MODE_LOAD: begin
                done <= 1'b1;
              end
              MODE_EVAL, MODE_UPD_X: begin
                state <= S_WLO;
              end
              MODE_SLOPE: begin
                if (spacing == '0) begin
                  value <= ONE_Q16;
                  status <= 1'b1;
                  done <= 1'b1;
                end else begin
                  state <= S_LDIV;
                end
              end
              MODE_UPD_M: begin
                seg <= (PW'(last_cell) > last) ? CW'(last) : last_cell;
                frac <= last_fraction;
                state <= S_RD0;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_WLO: begin
          after_hi <= 1'b1;
          if (xr < low) begin
            low <= xr;
            state <= S_MDIV;
          end else begin
            state <= S_WHI;
          end
        end
        S_WHI: begin
          after_hi <= 1'b0;
          if (xr > high) begin
            high <= xr;
            state <= S_MDIV;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (spacing == '0) begin
            status <= 1'b1;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_LDIV;
          end
        end
        S_MDIV: state <= S_MWAIT;
        S_MWAIT: begin
          mlo <= prod[47:0];
          state <= S_MSUM;
        end
        S_MSUM: begin
          low <= margin_low;
          high <= margin_high;
          state <= S_SDIV;
        end
        S_SDIV: state <= S_SWAIT;
        S_SWAIT: begin
          if (div_done) begin
            spacing <= spc_new;
            if (op == MODE_DOMAIN) begin
              status <= (spc_new == '0);
              done <= 1'b1;
              state <= S_IDLE;
            end else if (after_hi) begin
              state <= S_WHI;
            end else begin
              state <= S_CHK;
            end
          end
        end
        S_LDIV: state <= S_LWAIT;
        S_LWAIT: begin
          if (div_done) begin
            seg <= loc_cell;
            frac <= loc_frac;
            if (op == MODE_EVAL) begin
              last_cell <= loc_cell;
              last_fraction <= loc_frac;
            end
            state <= S_RD0;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          y0 <= ram_rdata;
          state <= S_RD2;
        end
        S_RD2: begin
          y1 <= ram_rdata;
          case (op)
            MODE_EVAL:  state <= S_IMUL;
            MODE_SLOPE: state <= S_SLDIV;
            default:    state <= S_U0;
          endcase
        end
        S_IMUL: state <= S_IRES;
        S_IRES: begin
          value <= sat32(64'(y0) + 64'(prod >>> 16));
          done <= 1'b1;
          state <= S_IDLE;
        end
        S_SLDIV: state <= S_SLWAIT;
        S_SLWAIT: begin
          if (div_done) begin
            value <= spc_new;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_U0: state <= S_U1;
        S_U1: begin
          d <= d_new;
          state <= S_U2;
        end
        S_U2: state <= S_U3;
        S_U3: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: dv/piecewise_linear_spline_trainer_unit_tb.sv
// testbench for the spline trainer: directed table, then random traffic checked by a predictor
module piecewise_linear_spline_trainer_unit_tb;
  import plst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int         KNOTS = MAX_KNOTS_DEF;

  typedef struct {
    logic [2:0]         mode;
    logic signed [31:0] x;
    logic signed [31:0] top;
    logic signed [31:0] delta;
    logic [5:0]         kidx;
    logic signed [31:0] kval;
    bit                 fixed;
    logic signed [31:0] fvalue;
    logic               fstatus;
  } cmd_t;

  typedef struct {
    logic signed [31:0] value;
    logic               status;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] mode = '0;
  logic signed [31:0] x = '0;
  logic signed [31:0] domain_top = '0;
  logic signed [31:0] delta = '0;
  logic [5:0] knot_index = '0;
  logic signed [31:0] knot_value = '0;
  logic done;
  logic signed [31:0] value;
  logic status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  piecewise_linear_spline_trainer_unit dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic signed [31:0] knots [KNOTS];
  logic signed [31:0] dom_lo, dom_hi, spc;
  logic [5:0]         mem_cell;
  logic [15:0]        mem_frac;
  logic [6:0]         pts;
  logic [23:0]        rate;

  res_t pending[$];
  int   errors = 0;
  int   sent = 0;
  int   checked = 0;
  int   per_mode [8];
  int   idle_pct = 0;
  cmd_t dir_rows [$];

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic signed [31:0] sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint npts();
    longint p = pts;
    if (p < 2) p = 2;
    if (p > KNOTS) p = KNOTS;
    return p;
  endfunction

  function automatic void add_margin();
    longint span = longint'(dom_hi) - longint'(dom_lo);
    longint mg = span / 100;
    dom_lo = sat(longint'(dom_lo) - mg);
    dom_hi = sat(longint'(dom_hi) + mg);
    spc = sat((longint'(dom_hi) - longint'(dom_lo)) / (npts() - 1));
  endfunction

  function automatic void widen_to(longint xv);
    if (xv < dom_lo) begin
      dom_lo = 32'(xv);
      add_margin();
    end
    if (xv > dom_hi) begin
      dom_hi = 32'(xv);
      add_margin();
    end
  endfunction

  function automatic void find_cell(longint xv, output int seg, output int frac);
    longint q = ((xv - longint'(dom_lo)) * 65536) / longint'(spc);
    longint last = npts() - 2;
    if (q < 0) begin
      seg = 0;
      frac = 0;
    end else if ((q >>> 16) > last) begin
      seg = int'(last);
      frac = 16'hffff;
    end else begin
      seg = int'(q >>> 16);
      frac = int'(q & 16'hffff);
    end
  endfunction

  function automatic void nudge_knots(int seg, int frac, longint dv);
    longint d = sat((dv * longint'(rate)) >>> 16);
    if (seg > npts() - 2) seg = int'(npts() - 2);
    knots[seg + 1] = sat(longint'(knots[seg + 1]) + ((d * frac) >>> 16));
    knots[seg] = sat(longint'(knots[seg]) + ((d * (65536 - frac)) >>> 16));
  endfunction

  function automatic res_t spline_result(cmd_t c);
    res_t r;
    int seg, frac;
    r.value = '0;
    r.status = 1'b0;
    case (c.mode)
      MODE_DOMAIN: begin
        dom_lo = c.x;
        dom_hi = c.top;
        add_margin();
        r.status = (spc == 0);
      end
      MODE_LOAD: knots[c.kidx] = c.kval;
      MODE_EVAL: begin
        widen_to(c.x);
        if (spc == 0) r.status = 1'b1;
        else begin
          find_cell(c.x, seg, frac);
          mem_cell = 6'(seg);
          mem_frac = 16'(frac);
          r.value = sat(longint'(knots[seg]) +
                        (((longint'(knots[seg + 1]) - knots[seg]) * frac) >>> 16));
        end
      end
      MODE_SLOPE: begin
        if (spc == 0) begin
          r.status = 1'b1;
          r.value = ONE_Q16;
        end else begin
          find_cell(c.x, seg, frac);
          r.value = sat(((longint'(knots[seg + 1]) - knots[seg]) * 65536) / longint'(spc));
        end
      end
      MODE_UPD_X: begin
        widen_to(c.x);
        if (spc == 0) r.status = 1'b1;
        else begin
          find_cell(c.x, seg, frac);
          nudge_knots(seg, frac, c.delta);
        end
      end
      MODE_UPD_M: nudge_knots(mem_cell, mem_frac, c.delta);
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending.size() == 0) begin
        report("unexpected result value", value, 0);
      end else begin
        res_t e;
        e = pending.pop_front();
        if (value !== e.value) report("value", value, e.value);
        if (status !== e.status) report("status", status, e.status);
        checked++;
      end
    end
  end

  task automatic issue(cmd_t c);
    res_t r;
    if (!start) start <= 1'b1;
    mode <= c.mode;
    x <= c.x;
    domain_top <= c.top;
    delta <= c.delta;
    knot_index <= c.kidx;
    knot_value <= c.kval;
    do @(posedge clk); while (busy);
    r = spline_result(c);
    if (c.fixed) begin
      r.value = c.fvalue;
      r.status = c.fstatus;
    end
    pending.push_back(r);
    sent++;
    per_mode[c.mode]++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (start) start <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_POINTS) pts = data[6:0];
    else rate = data;
  endtask

  function automatic cmd_t mk(logic [2:0] m, logic signed [31:0] xv, logic signed [31:0] tv,
                              logic signed [31:0] dv, logic [5:0] ki, logic signed [31:0] kv,
                              bit fx = 0, logic signed [31:0] fv = 0, logic fs = 0);
    cmd_t c;
    c.mode = m; c.x = xv; c.top = tv; c.delta = dv; c.kidx = ki; c.kval = kv;
    c.fixed = fx; c.fvalue = fv; c.fstatus = fs;
    return c;
  endfunction

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom;
      default: return $signed($urandom) >>> $urandom_range(4, 14);
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_x();
    longint span = longint'(dom_hi) - longint'(dom_lo);
    int sel = $urandom_range(99);
    if (sel < 75 && span > 0) return 32'(dom_lo + longint'({$urandom, $urandom} % (span + 1)));
    if (sel < 88) return 32'(dom_hi + $signed($urandom_range(0, 1 << 20)) -
                             (($urandom_range(1)) ? 0 : span + (1 << 20)));
    return $urandom;
  endfunction

  function automatic cmd_t rnd_cmd();
    int sel = $urandom_range(99);
    logic signed [31:0] lo, hi;
    logic signed [31:0] dv = ($urandom_range(3) == 0) ? rnd_val() : $signed($urandom) >>> 8;
    if (sel < 6) begin
      lo = $signed($urandom) >>> $urandom_range(1, 10);
      hi = lo + $urandom_range(0, 1 << 24);
      case ($urandom_range(9))
        0: hi = lo;
        1: begin lo = $urandom; hi = $urandom; end
        2: begin hi = lo - $urandom_range(1, 1 << 22); end
        default: ;
      endcase
      return mk(MODE_DOMAIN, lo, hi, dv, 6'($urandom), $urandom);
    end
    if (sel < 22) return mk(MODE_LOAD, $urandom, $urandom, dv, 6'($urandom), rnd_val());
    if (sel < 50) return mk(MODE_EVAL, rnd_x(), $urandom, dv, 6'($urandom), $urandom);
    if (sel < 62) return mk(MODE_SLOPE, rnd_x(), $urandom, dv, 6'($urandom), $urandom);
    if (sel < 78) return mk(MODE_UPD_X, rnd_x(), $urandom, dv, 6'($urandom), $urandom);
    if (sel < 96) return mk(MODE_UPD_M, $urandom, $urandom, dv, 6'($urandom), $urandom);
    return mk(sel[0] ? MODE_SPARE6 : MODE_SPARE7, $urandom, $urandom, $urandom,
              6'($urandom), $urandom, 1, 0, 0);
  endfunction

  initial begin
    int pct [4];
    logic [23:0] pts_set [4];
    logic [23:0] rate_set [4];
    pct = '{0, 80, 0, 37};
    pts_set = '{24'd64, 24'd2, 24'd127, 24'd0};
    rate_set = '{24'd655, 24'd0, 24'hffffff, 24'd40000};
    dom_lo = 0; dom_hi = 0; spc = 0; mem_cell = 0; mem_frac = 0;
    pts = POINTS_RESET; rate = RATE_RESET;
    foreach (knots[i]) knots[i] = 0;
    foreach (per_mode[i]) per_mode[i] = 0;

    // zero spacing after reset, nothing in the table is read
    dir_rows.push_back(mk(MODE_EVAL, 0, 0, 0, 0, 0, 1, 0, 1));
    dir_rows.push_back(mk(MODE_SLOPE, 0, 0, 0, 0, 0, 1, ONE_Q16, 1));
    dir_rows.push_back(mk(MODE_UPD_X, 0, 0, 32'sh7fffffff, 0, 0, 1, 0, 1));
    dir_rows.push_back(mk(MODE_SPARE6, -1, -1, -1, 63, -1, 1, 0, 0));
    dir_rows.push_back(mk(MODE_SPARE7, 0, 0, 0, 0, 0, 1, 0, 0));
    // table filled after these rows
    dir_rows.push_back(mk(MODE_DOMAIN, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 1, 0, 0));
    dir_rows.push_back(mk(MODE_EVAL, 32'sh80000000, 0, 0, 0, 0));
    dir_rows.push_back(mk(MODE_EVAL, 32'sh7fffffff, 0, 0, 0, 0));
    dir_rows.push_back(mk(MODE_LOAD, 0, 0, 0, 0, 32'sh7fffffff, 1, 0, 0));
    dir_rows.push_back(mk(MODE_LOAD, 0, 0, 0, 1, 32'sh80000000, 1, 0, 0));
    dir_rows.push_back(mk(MODE_SLOPE, 32'sh80000000, 0, 0, 0, 0));
    dir_rows.push_back(mk(MODE_EVAL, 32'sh80000000 + 1000, 0, 0, 0, 0));
    dir_rows.push_back(mk(MODE_UPD_M, 0, 0, 32'sh7fffffff, 0, 0));
    dir_rows.push_back(mk(MODE_UPD_M, 0, 0, 32'sh80000000, 0, 0));
    dir_rows.push_back(mk(MODE_DOMAIN, 5, 5, 0, 0, 0, 1, 0, 1));
    dir_rows.push_back(mk(MODE_DOMAIN, -32'sd655360, 32'sd655360, 0, 0, 0, 1, 0, 0));
    dir_rows.push_back(mk(MODE_EVAL, -32'sd2000000, 0, 0, 0, 0));
    dir_rows.push_back(mk(MODE_UPD_X, 32'sd3000000, 0, 32'sd65536, 0, 0));
    dir_rows.push_back(mk(MODE_SLOPE, 32'sd9000000, 0, 0, 0, 0));
    dir_rows.push_back(mk(MODE_DOMAIN, 32'sd655360, -32'sd655360, 0, 0, 0, 1, 0, 0));
    dir_rows.push_back(mk(MODE_EVAL, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(MODE_SLOPE, 32'sd600000, 0, 0, 0, 0));
    dir_rows.push_back(mk(MODE_UPD_X, -32'sd600000, 0, -32'sd123456, 0, 0));
    dir_rows.push_back(mk(MODE_UPD_M, 0, 0, 32'sd77777, 0, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (i == 5) begin
        for (int k = 0; k < KNOTS; k++)
          issue(mk(MODE_LOAD, 0, 0, 0, 6'(k), $signed($urandom) >>> 12, 1, 0, 0));
      end
      issue(dir_rows[i]);
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      cfg_write(REG_POINTS, pts_set[ph]);
      cfg_write(REG_RATE, rate_set[ph]);
      if (ph == 3) cfg_write(REG_POINTS, 24'($urandom_range(3, 63)));
      idle_pct = pct[ph];
      for (int n = 0; n < 500; n++) begin
        if (n == 250) drain();
        issue(rnd_cmd());
      end
    end

    drain();
    begin
      int waited;
      waited = 0;
      while (pending.size() != 0 && waited < 5000) begin
        @(posedge clk);
        waited++;
      end
    end
    repeat (200) @(posedge clk);
    if (pending.size() != 0) report("results left outstanding", pending.size(), 0);
    $display("ran %0d commands, %0d results checked over four idle and register settings",
             sent, checked);
    $display("mode counts: domain %0d load %0d eval %0d slope %0d update %0d recall %0d",
             per_mode[0], per_mode[1], per_mode[2], per_mode[3], per_mode[4], per_mode[5]);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #80ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/plst_pkg.sv
hw/rtl/plst_ram.sv
hw/rtl/plst_div.sv
hw/rtl/plst_mul.sv
hw/rtl/piecewise_linear_spline_trainer_unit.sv
dv/piecewise_linear_spline_trainer_unit_tb.sv
